// ----- rtl/dep_pkg.sv -----
package dep_pkg;

    // event word codes
    localparam logic [15:0] END_WORD = 16'hFF00;

    // multiplicity cap
    localparam int MAX_MULT = 40;
    localparam int MULT_W = 6;
    localparam logic [MULT_W-1:0] MAX_MULT_C = MULT_W'(MAX_MULT);

    // station and count limits
    localparam logic [10:0] LAST_ENERGY_STATION = 11'd9;
    localparam logic [4:0] TIME_COUNT_DEFAULT = 5'd16;
    localparam logic [3:0] ENERGY_COUNT_LIMIT = 4'd3;
    localparam logic [4:0] WORDS_MAX = 5'd31;

    // result kinds
    localparam logic KIND_ENERGY = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [10:0]       station;
        logic [4:0]        group_words;
        logic [4:0]        expected_words;
        logic [MULT_W-1:0] energy_count;
        logic              bad_flag;
    } dep_state_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [12:0]       energy;
        logic [MULT_W-1:0] slot;
        logic [MULT_W-1:0] multiplicity;
        logic              bad_event;
    } dep_result_t;

endpackage

// ----- rtl/detector_event_parser.sv -----
// path: an accepted word goes into the input register, is decoded, and lands in the result register
// throughput: one word per cycle while the output is not stalled, set by the single decode stage
//   between the input register and the result register
// a stalled output holds the result and, while the input register holds a word, stalls the input
// reset clears the event state, the input stage valid and the output valid
module detector_event_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [15:0]                 word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [12:0]                 energy,
    output logic [dep_pkg::MULT_W-1:0]  slot,
    output logic [dep_pkg::MULT_W-1:0]  multiplicity,
    output logic                        bad_event
);

    logic                 in_valid_reg;
    logic [15:0]          word_reg;
    dep_pkg::dep_state_t  state_reg;
    dep_pkg::dep_state_t  state_next;
    dep_pkg::dep_result_t result_next;
    dep_pkg::dep_result_t result_reg;
    logic                 out_free;
    logic                 advance;

    // handshake control
    assign out_free = !result_reg.valid || !out_stall;
    assign advance = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg <= word;
        end
    end

    // decode
    dep_decode u_decode
    (
        .word       (word_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (out_free)
        begin
            result_reg <= advance ? result_next : '0;
        end
    end

    assign out_valid = result_reg.valid;
    assign kind = result_reg.kind;
    assign energy = result_reg.energy;
    assign slot = result_reg.slot;
    assign multiplicity = result_reg.multiplicity;
    assign bad_event = result_reg.bad_event;

`ifndef ASSERT_OFF
    // energy slots stay below the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == dep_pkg::KIND_ENERGY)) |-> (slot < dep_pkg::MAX_MULT_C))
        else $error("energy slot at or above cap");

    // a bad event reports zero multiplicity
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == dep_pkg::KIND_SUMMARY) && bad_event) |-> (multiplicity == '0))
        else $error("bad event with nonzero multiplicity");

    // energy count never passes the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.energy_count <= dep_pkg::MAX_MULT_C)
        else $error("energy count above cap");

    // input stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && in_valid_reg))
        else $error("input stalled without output backpressure");

    // a summary clears the event state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result_next.valid && (result_next.kind == dep_pkg::KIND_SUMMARY))
        |=> (state_reg == '0))
        else $error("state not cleared after summary");
`endif

endmodule

// ----- rtl/dep_decode.sv -----
module dep_decode
(
    input  logic [15:0]        word,
    input  dep_pkg::dep_state_t  state,
    output dep_pkg::dep_state_t  state_next,
    output dep_pkg::dep_result_t result
);

    logic [10:0] hdr_station;
    logic [4:0]  hdr_count;

    assign hdr_station = word[10:0];

    // classify the word and work out the next state and any result
    always_comb
    begin
        state_next = state;
        result = '0;
        hdr_count = {1'b0, word[14:11]};
        priority if (word == dep_pkg::END_WORD)
        begin
            // end of event: summary, then clear
            result.valid = 1'b1;
            result.kind = dep_pkg::KIND_SUMMARY;
            result.multiplicity = state.bad_flag ? '0 : state.energy_count;
            result.bad_event = state.bad_flag;
            state_next = '0;
        end
        else if (word[15])
        begin
            // station header checks
            if ((state.group_words != state.expected_words) ||
                (hdr_station <= state.station))
            begin
                state_next.bad_flag = 1'b1;
            end
            if (hdr_station > dep_pkg::LAST_ENERGY_STATION)
            begin
                if (hdr_count == 5'd0)
                begin
                    hdr_count = dep_pkg::TIME_COUNT_DEFAULT;
                end
            end
            else if (word[14:11] > dep_pkg::ENERGY_COUNT_LIMIT)
            begin
                state_next.bad_flag = 1'b1;
            end
            state_next.station = hdr_station;
            state_next.group_words = 5'd0;
            state_next.expected_words = hdr_count;
        end
        else
        begin
            // data word: saturating group count, energy while under the cap at an energy station
            if (state.group_words < dep_pkg::WORDS_MAX)
            begin
                state_next.group_words = state.group_words + 5'd1;
            end
            if ((state.energy_count < dep_pkg::MAX_MULT_C) &&
                (state.station <= dep_pkg::LAST_ENERGY_STATION))
            begin
                result.valid = 1'b1;
                result.kind = dep_pkg::KIND_ENERGY;
                result.energy = word[12:0];
                result.slot = state.energy_count;
                result.bad_event = state.bad_flag;
                state_next.energy_count = state.energy_count + dep_pkg::MULT_W'(1);
            end
        end
    end

endmodule

// ----- test/event_checker.sv -----
module event_checker
    import dep_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [15:0]       word,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              kind,
    input  logic [12:0]       energy,
    input  logic [MULT_W-1:0] slot,
    input  logic [MULT_W-1:0] multiplicity,
    input  logic              bad_event,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [12:0]       energy;
        logic [MULT_W-1:0] slot;
        logic [MULT_W-1:0] multiplicity;
        logic              bad_event;
    } parser_result_t;

    // event state as the predictor tracks it
    logic [10:0]       cur_station = '0;
    logic [4:0]        group_cnt = '0;
    logic [4:0]        announced = '0;
    logic [MULT_W-1:0] energies = '0;
    logic              event_bad = 1'b0;

    parser_result_t expected_results[$];
    int error_count = 0;
    int waiting = 0;

    assign errors = error_count;
    assign pending = waiting;

    task automatic clear_event();
        cur_station = '0;
        group_cnt = '0;
        announced = '0;
        energies = '0;
        event_bad = 1'b0;
    endtask

    // decode one word, update the event state and give the result it causes
    task automatic parse_word(input logic [15:0] w, output bit produced,
                              output parser_result_t r);
        logic [4:0] field;
        produced = 1'b0;
        r = '0;
        if (w == END_WORD)
        begin
            r.kind = KIND_SUMMARY;
            r.multiplicity = event_bad ? '0 : energies;
            r.bad_event = event_bad;
            produced = 1'b1;
            clear_event();
        end
        else if (w[15])
        begin
            // station header: counts of the previous group must match first
            field = {1'b0, w[14:11]};
            if (group_cnt != announced)
                event_bad = 1'b1;
            else if (w[10:0] <= cur_station)
                event_bad = 1'b1;
            cur_station = w[10:0];
            group_cnt = '0;
            if (w[10:0] > LAST_ENERGY_STATION)
            begin
                if (field == '0)
                    field = TIME_COUNT_DEFAULT;
            end
            else if (w[14:11] > ENERGY_COUNT_LIMIT)
            begin
                event_bad = 1'b1;
            end
            announced = field;
        end
        else
        begin
            // data word: counts up to the saturation limit, reports energy only below the cap at an energy station
            if (group_cnt < WORDS_MAX)
                group_cnt = group_cnt + 5'd1;
            if (energies < MAX_MULT_C && cur_station <= LAST_ENERGY_STATION)
            begin
                r.kind = KIND_ENERGY;
                r.energy = w[12:0];
                r.slot = energies;
                r.bad_event = event_bad;
                produced = 1'b1;
                energies = energies + 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        parser_result_t want_r;
        bit produced;
        if (!rst_n)
        begin
            clear_event();
            expected_results.delete();
            waiting = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual kind %0d energy %0d slot %0d mult %0d bad %0d"},
                             $time, kind, energy, slot, multiplicity, bad_event);
                    error_count++;
                end
                else
                begin
                    want_r = expected_results.pop_front();
                    check_field("kind", 16'(want_r.kind), 16'(kind));
                    check_field("energy", 16'(want_r.energy), 16'(energy));
                    check_field("slot", 16'(want_r.slot), 16'(slot));
                    check_field("multiplicity", 16'(want_r.multiplicity),
                                16'(multiplicity));
                    check_field("bad_event", 16'(want_r.bad_event), 16'(bad_event));
                end
            end
            if (in_valid && !in_stall)
            begin
                parse_word(word, produced, want_r);
                if (produced)
                    expected_results.push_back(want_r);
            end
            waiting = expected_results.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dep_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 370;
    localparam int HOLD_CYCLES = 200;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [15:0]       word = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              kind;
    logic [12:0]       energy;
    logic [MULT_W-1:0] slot;
    logic [MULT_W-1:0] multiplicity;
    logic              bad_event;

    int errors;
    int pending;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned sent_count = 0;
    int unsigned cycle_count = 0;

    logic [15:0] event_words[$];

    detector_event_parser dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .word         (word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .energy       (energy),
        .slot         (slot),
        .multiplicity (multiplicity),
        .bad_event    (bad_event)
    );

    event_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .word         (word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .energy       (energy),
        .slot         (slot),
        .multiplicity (multiplicity),
        .bad_event    (bad_event),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result side stall, with a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // offer one request and wait for its acceptance
    task automatic send_word(input logic [15:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering until every expected result is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one event: mostly well formed groups, some with a single flaw, some noise
    task automatic build_event(input bit cap_run);
        int unsigned pick;
        int unsigned groups;
        int unsigned flaw;
        int unsigned flaw_group;
        int unsigned prev;
        int unsigned stn;
        int unsigned field;
        int unsigned ndata;
        int unsigned g;
        logic [15:0] hdr;
        event_words.delete();
        pick = $urandom_range(0, 99);
        if (!cap_run && pick < 10)
        begin
            repeat ($urandom_range(1, 20)) event_words.push_back(16'($urandom));
            if (pick < 7)
                event_words.push_back(END_WORD);
            return;
        end
        groups = cap_run ? 1 : $urandom_range(1, 5);
        flaw = cap_run ? 5 : ((pick < 32) ? $urandom_range(1, 5) : 0);
        flaw_group = (flaw == 5) ? groups - 1 : $urandom_range(0, groups - 1);
        prev = 0;
        for (g = 0; g < groups && prev < 2047; g++)
        begin
            if (prev < 9 && $urandom_range(0, 1))
                stn = $urandom_range(prev + 1, 9);
            else
                stn = $urandom_range((prev < 10) ? 10 : prev + 1,
                                     (prev > 1747) ? 2047 : prev + 300);
            field = (stn <= 9) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            if (g == flaw_group)
            begin
                case (flaw)
                    2: stn = $urandom_range(0, prev);
                    3:
                    begin
                        stn = $urandom_range(0, 9);
                        field = $urandom_range(4, 15);
                    end
                    5:
                    begin
                        stn = (prev < 9) ? $urandom_range(prev + 1, 9) : $urandom_range(0, 9);
                        field = $urandom_range(0, 3);
                    end
                    default: ;
                endcase
            end
            ndata = (stn > 9 && field == 0) ? 16 : field;
            if (g == flaw_group)
            begin
                // wrong word count, saturating count, or a group past the cap
                case (flaw)
                    1:
                    begin
                        if (ndata > 0 && $urandom_range(0, 1))
                            ndata--;
                        else
                            ndata++;
                    end
                    4: ndata = $urandom_range(31, 36);
                    5: ndata = $urandom_range(38, 50);
                    default: ;
                endcase
            end
            hdr = {1'b1, 4'(field), 11'(stn)};
            if (hdr == END_WORD)
                hdr[0] = 1'b1;
            event_words.push_back(hdr);
            repeat (ndata) event_words.push_back({1'b0, 15'($urandom)});
            prev = stn;
        end
        event_words.push_back(END_WORD);
    endtask

    initial
    begin
        logic [15:0] directed[$];
        int unsigned phase_start;
        bit paused;
        // zero station first, field extremes, zero count, mismatch, order, oversize count
        directed = '{16'h8000, 16'h1FFF, 16'h6000, END_WORD,
                     16'h9005, 16'h0000, 16'h7FFF, 16'h800A, 16'h2AAA, 16'h880B,
                     16'h5555, END_WORD,
                     16'h8809, 16'h4321, 16'h8805, 16'h1234, END_WORD,
                     16'hA003, END_WORD,
                     16'hFFFF, END_WORD,
                     END_WORD,
                     16'hFF01, END_WORD};
        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 82;
        foreach (directed[i])
            send_word(directed[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = sent_count;
            // long result hold-off while energies keep coming in
            if (phase == 2)
            begin
                hold_req = 1'b1;
                build_event(1'b1);
                foreach (event_words[i])
                    send_word(event_words[i]);
            end
            while (sent_count - phase_start < PHASE_ITEMS)
            begin
                build_event(1'b0);
                foreach (event_words[i])
                    send_word(event_words[i]);
                if (phase == 0 && !paused && sent_count - phase_start > PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
